/* hdl/segment_direction_rescale_3d_assert.svh */
// Assertion macros shared by the segment direction rescale block.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef SEGMENT_DIRECTION_RESCALE_3D_ASSERT_SVH
`define SEGMENT_DIRECTION_RESCALE_3D_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define SDR_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sdr check failed");

// antecedent implies consequent in the next cycle
`define SDR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sdr check failed");

`endif

/* hdl/sdr_pkg.sv */
// Shared widths and types for the segment direction rescale block.
// No dependencies.
package sdr_pkg;

    localparam int COORD_WIDTH = 24;
    localparam int LW  = COORD_WIDTH - 1;   // segment length width
    localparam int DW  = COORD_WIDTH + 1;   // difference / magnitude width
    localparam int SQW = 2 * DW;            // one square
    localparam int SW  = SQW + 2;           // sum of three squares, even
    localparam int RW  = SW / 2;            // square root width
    localparam int RMW = RW + 2;            // root remainder width
    localparam int PW  = DW + LW;           // |d| * length
    localparam int QW  = LW;                // quotient never exceeds length
    localparam int DRW = RW + 1;            // divider remainder width
    localparam int NL  = 3;                 // lanes x, y, z

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic [LW-1:0]  len_t;
    typedef logic [DW-1:0]  abs_t;
    typedef logic [SQW-1:0] sq_t;
    typedef logic [SW-1:0]  sum_t;
    typedef logic [RW-1:0]  root_t;
    typedef logic [QW-1:0]  quot_t;
    typedef logic [PW-1:0]  prod_t;

endpackage

/* hdl/sdr_lane_front.sv */
// One lane front end: difference, magnitude and square, two stages.
// Depends on sdr_pkg.
module sdr_lane_front (
    input  logic            clk,
    input  logic            en,
    input  sdr_pkg::coord_t from_c,
    input  sdr_pkg::coord_t to_c,
    output sdr_pkg::abs_t   abs_o,
    output logic            neg_o,
    output sdr_pkg::sq_t    sq_o
);
    import sdr_pkg::*;

    abs_t d_next;
    abs_t abs_a_reg, abs_b_reg;
    logic neg_a_reg, neg_b_reg;
    sq_t  sq_reg;

    assign d_next = {to_c[COORD_WIDTH-1], to_c} - {from_c[COORD_WIDTH-1], from_c};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg_a_reg <= d_next[DW-1];
            abs_a_reg <= d_next[DW-1] ? (~d_next + abs_t'(1)) : d_next;
            neg_b_reg <= neg_a_reg;
            abs_b_reg <= abs_a_reg;
            sq_reg    <= SQW'(abs_a_reg) * SQW'(abs_a_reg);
        end
    end

    assign abs_o = abs_b_reg;
    assign neg_o = neg_b_reg;
    assign sq_o  = sq_reg;
endmodule

/* hdl/sdr_isqrt.sv */
// Pipelined integer square root, two radicand bits per stage.
// Depends on sdr_pkg.
module sdr_isqrt (
    input  logic          clk,
    input  logic          en,
    input  sdr_pkg::sum_t s_in,
    output sdr_pkg::root_t root_o
);
    import sdr_pkg::*;

    sum_t              s_reg    [RW];
    root_t             root_reg [RW];
    logic [RMW-1:0]    rem_reg  [RW];

    for (genvar i = 0; i < RW; i++)
    begin : g_stage
        sum_t           s_prev;
        root_t          root_prev;
        logic [RMW-1:0] rem_prev, rem2, trial;

        if (i == 0)
        begin : g_first
            assign s_prev    = s_in;
            assign root_prev = '0;
            assign rem_prev  = '0;
        end
        else
        begin : g_rest
            assign s_prev    = s_reg[i-1];
            assign root_prev = root_reg[i-1];
            assign rem_prev  = rem_reg[i-1];
        end

        assign rem2  = {rem_prev[RMW-3:0], s_prev[SW-1:SW-2]};
        assign trial = {root_prev, 2'b01};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                s_reg[i] <= {s_prev[SW-3:0], 2'b00};
                if (rem2 >= trial)
                begin
                    rem_reg[i]  <= rem2 - trial;
                    root_reg[i] <= {root_prev[RW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[i]  <= rem2;
                    root_reg[i] <= {root_prev[RW-2:0], 1'b0};
                end
            end
        end
    end

    assign root_o = root_reg[RW-1];
endmodule

/* hdl/sdr_lane_div.sv */
// One lane back end: |d| * length, then a restoring divide by the magnitude,
// one quotient bit per stage. Depends on sdr_pkg.
module sdr_lane_div (
    input  logic           clk,
    input  logic           en,
    input  sdr_pkg::abs_t  abs_i,
    input  logic           neg_i,
    input  sdr_pkg::len_t  len_i,
    input  sdr_pkg::root_t mag_i,
    output sdr_pkg::quot_t q_o,
    output logic           neg_o
);
    import sdr_pkg::*;

    prod_t          p_reg;
    root_t          mag0_reg;
    logic           neg0_reg;

    logic [DRW-1:0] r_reg   [QW];
    quot_t          num_reg [QW];   // dividend bits still to shift in
    quot_t          q_reg   [QW];
    root_t          mag_reg [QW];
    logic           neg_reg [QW];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg    <= PW'(abs_i) * PW'(len_i);
            mag0_reg <= mag_i;
            neg0_reg <= neg_i;
        end
    end

    for (genvar i = 0; i < QW; i++)
    begin : g_stage
        logic [DRW-1:0] r_prev, r2;
        quot_t          num_prev, q_prev;
        root_t          mag_prev;
        logic           neg_prev;

        if (i == 0)
        begin : g_first
            // quotient fits QW bits, so the top part is already below mag
            assign r_prev   = DRW'(p_reg[PW-1:QW]);
            assign num_prev = p_reg[QW-1:0];
            assign q_prev   = '0;
            assign mag_prev = mag0_reg;
            assign neg_prev = neg0_reg;
        end
        else
        begin : g_rest
            assign r_prev   = r_reg[i-1];
            assign num_prev = num_reg[i-1];
            assign q_prev   = q_reg[i-1];
            assign mag_prev = mag_reg[i-1];
            assign neg_prev = neg_reg[i-1];
        end

        assign r2 = {r_prev[DRW-2:0], num_prev[QW-1]};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                num_reg[i] <= {num_prev[QW-2:0], 1'b0};
                mag_reg[i] <= mag_prev;
                neg_reg[i] <= neg_prev;
                if (r2 >= {1'b0, mag_prev})
                begin
                    r_reg[i] <= r2 - {1'b0, mag_prev};
                    q_reg[i] <= {q_prev[QW-2:0], 1'b1};
                end
                else
                begin
                    r_reg[i] <= r2;
                    q_reg[i] <= {q_prev[QW-2:0], 1'b0};
                end
            end
        end
    end

    assign q_o   = q_reg[QW-1];
    assign neg_o = neg_reg[QW-1];
endmodule

/* hdl/segment_direction_rescale_3d.sv */
// Pipeline of 2 + 1 + RW + 1 + QW + 1 register stages (54 at 24-bit coordinates).
// Throughput: one transfer per cycle; the whole pipeline advances together
// whenever the output register is empty or being taken.
// Depth is set by the square root (one stage per root bit) and the
// per-lane restoring dividers (one stage per quotient bit).
// Reset clears only the valid bits; payload registers are not reset.
module segment_direction_rescale_3d (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  sdr_pkg::coord_t from_x,
    input  sdr_pkg::coord_t from_y,
    input  sdr_pkg::coord_t from_z,
    input  sdr_pkg::coord_t to_x,
    input  sdr_pkg::coord_t to_y,
    input  sdr_pkg::coord_t to_z,
    input  sdr_pkg::len_t   seg_length,
    output logic            out_valid,
    input  logic            out_ready,
    output sdr_pkg::coord_t out_x,
    output sdr_pkg::coord_t out_y,
    output sdr_pkg::coord_t out_z,
    output logic            status
);
    import sdr_pkg::*;
    `include "segment_direction_rescale_3d_assert.svh"

    localparam int NSTG = 2 + 1 + RW + 1 + QW + 1;

    logic            en;
    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] vld_next;

    coord_t from_c [NL];
    coord_t to_c   [NL];
    abs_t   abs_b  [NL];
    logic   neg_b  [NL];
    sq_t    sq_b   [NL];

    len_t   len_a_reg, len_b_reg, len_c_reg;
    sum_t   s_reg;
    abs_t   abs_c_reg [NL];
    logic   neg_c_reg [NL];

    // side data riding alongside the square root
    len_t   len_d_reg  [RW];
    abs_t   abs_d_reg  [RW][NL];
    logic   neg_d_reg  [RW][NL];
    logic   zero_d_reg [RW + 1 + QW];

    root_t  mag;
    quot_t  q    [NL];
    logic   qneg [NL];

    coord_t res_reg [NL];
    logic   status_reg;

    assign en       = !vld_reg[NSTG-1] || out_ready;
    assign in_ready = en;
    assign vld_next = {vld_reg[NSTG-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= vld_next;
    end

    assign from_c[0] = from_x;
    assign from_c[1] = from_y;
    assign from_c[2] = from_z;
    assign to_c[0]   = to_x;
    assign to_c[1]   = to_y;
    assign to_c[2]   = to_z;

    for (genvar l = 0; l < NL; l++)
    begin : g_lane
        sdr_lane_front u_front (
            .clk    (clk),
            .en     (en),
            .from_c (from_c[l]),
            .to_c   (to_c[l]),
            .abs_o  (abs_b[l]),
            .neg_o  (neg_b[l]),
            .sq_o   (sq_b[l])
        );

        sdr_lane_div u_div (
            .clk   (clk),
            .en    (en),
            .abs_i (abs_d_reg[RW-1][l]),
            .neg_i (neg_d_reg[RW-1][l]),
            .len_i (len_d_reg[RW-1]),
            .mag_i (mag),
            .q_o   (q[l]),
            .neg_o (qneg[l])
        );
    end

    // merge: sum of the three lane squares
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            len_a_reg <= seg_length;
            len_b_reg <= len_a_reg;
            len_c_reg <= len_b_reg;
            s_reg     <= SW'(sq_b[0]) + SW'(sq_b[1]) + SW'(sq_b[2]);
            for (int l = 0; l < NL; l++)
            begin
                abs_c_reg[l] <= abs_b[l];
                neg_c_reg[l] <= neg_b[l];
            end
        end
    end

    sdr_isqrt u_isqrt (
        .clk    (clk),
        .en     (en),
        .s_in   (s_reg),
        .root_o (mag)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            len_d_reg[0]  <= len_c_reg;
            zero_d_reg[0] <= (s_reg == '0);
            for (int l = 0; l < NL; l++)
            begin
                abs_d_reg[0][l] <= abs_c_reg[l];
                neg_d_reg[0][l] <= neg_c_reg[l];
            end
            for (int i = 1; i < RW; i++)
            begin
                len_d_reg[i] <= len_d_reg[i-1];
                for (int l = 0; l < NL; l++)
                begin
                    abs_d_reg[i][l] <= abs_d_reg[i-1][l];
                    neg_d_reg[i][l] <= neg_d_reg[i-1][l];
                end
            end
            for (int i = 1; i < RW + 1 + QW; i++)
                zero_d_reg[i] <= zero_d_reg[i-1];
        end
    end

    // output register: apply sign, force zero for coinciding points
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            status_reg <= zero_d_reg[RW + QW];
            for (int l = 0; l < NL; l++)
            begin
                if (zero_d_reg[RW + QW])
                    res_reg[l] <= '0;
                else if (qneg[l])
                    res_reg[l] <= -coord_t'({1'b0, q[l]});
                else
                    res_reg[l] <= coord_t'({1'b0, q[l]});
            end
        end
    end

    assign out_valid = vld_reg[NSTG-1];
    assign out_x     = res_reg[0];
    assign out_y     = res_reg[1];
    assign out_z     = res_reg[2];
    assign status    = status_reg;

    `SDR_ASSERT_NOW(a_status_zero, out_valid && status, out_x == '0 && out_y == '0 && out_z == '0)
    `SDR_ASSERT_NEXT(a_stall_holds, !en, $stable(vld_reg))
    `SDR_ASSERT_NEXT(a_out_kept, out_valid && !out_ready, out_valid)
endmodule
